>>> rtl/brfo_pkg.sv
// ----------------------------------------------------------------------------
// brfo_pkg
// Shared types and codes for the byte ring FIFO with overwrite.
// ----------------------------------------------------------------------------
package brfo_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_PEEK  = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_DROPPED = 2'd3
    } brfo_status_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] wdata;
    } brfo_in_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic [1:0] status;
        logic       is_full;
        logic       is_empty;
    } brfo_out_t;

    // per-transaction result info held next to the memory read data
    typedef struct packed {
        logic         rd_ok;
        brfo_status_t status;
        logic         is_full;
        logic         is_empty;
    } brfo_meta_t;

endpackage

>>> rtl/brfo_mem.sv
// ----------------------------------------------------------------------------
// brfo_mem
// Byte storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brfo_mem #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read, so a stalled result stays put
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/brfo_ctrl.sv
// ----------------------------------------------------------------------------
// brfo_ctrl
// Pointer and flag update, memory access issue and result info register.
// ----------------------------------------------------------------------------
module brfo_ctrl #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_en,
    input  logic                cfg_data,
    input  logic                accept,
    input  brfo_pkg::brfo_in_t  item,
    input  logic                out_taken,
    output logic                we,
    output logic                re,
    output logic [AW-1:0]       addr,
    output logic                out_valid,
    output brfo_pkg::brfo_meta_t meta
);
    import brfo_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic          overwrite_reg;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic          full_reg, full_next;
    logic          valid_reg, valid_next;
    brfo_meta_t    meta_reg, meta_next;

    logic [AW-1:0] wp_inc, rp_inc;
    logic          empty_now;

    assign wp_inc    = (wp_reg == LAST) ? '0 : wp_reg + AW'(1);
    assign rp_inc    = (rp_reg == LAST) ? '0 : rp_reg + AW'(1);
    assign empty_now = (wp_reg == rp_reg) && !full_reg;

    always_comb
    begin
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        full_next        = full_reg;
        we               = 1'b0;
        re               = 1'b0;
        meta_next.rd_ok  = 1'b0;
        meta_next.status = STATUS_OK;
        unique case (item.mode) inside
            MODE_WRITE:
            begin
                if (full_reg)
                begin
                    meta_next.status = STATUS_FULL;
                end
                else
                begin
                    we      = accept;
                    wp_next = wp_inc;
                    if (wp_inc == rp_reg)
                    begin
                        if (overwrite_reg)
                        begin
                            rp_next          = rp_inc;
                            meta_next.status = STATUS_DROPPED;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                end
            end
            MODE_READ, MODE_PEEK:
            begin
                if (empty_now)
                begin
                    meta_next.status = STATUS_EMPTY;
                end
                else
                begin
                    re              = accept;
                    meta_next.rd_ok = 1'b1;
                    if (item.mode == MODE_READ)
                    begin
                        rp_next   = rp_inc;
                        full_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        meta_next.is_full  = full_next;
        meta_next.is_empty = (wp_next == rp_next) && !full_next;
    end

    assign addr = (item.mode == MODE_WRITE) ? wp_reg : rp_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (out_taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overwrite_reg <= 1'b0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            full_reg      <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_en)
            begin
                overwrite_reg <= cfg_data;
            end
            if (accept)
            begin
                wp_reg   <= wp_next;
                rp_reg   <= rp_next;
                full_reg <= full_next;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meta_reg <= meta_next;
        end
    end

    assign out_valid = valid_reg;
    assign meta      = meta_reg;

endmodule

>>> rtl/byte_ring_fifo_overwrite.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_overwrite
// Byte ring buffer with write, read and peek transactions and optional
// overwrite of the oldest byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one operation per transaction: write,
//   read or peek. out_valid/out_stall/out_data return exactly one result
//   per operation: read byte, status and the flags after the operation.
//   cfg_en/cfg_data write the overwrite-oldest bit; the user must do so only
//   while the block is idle, which the block does not enforce. The result is
//   valid in the cycle after acceptance; the byte comes from the memory's
//   registered read port. Throughput is one operation per cycle while the
//   receiver takes results. When the receiver stalls, the result register
//   and read data hold and in_stall is raised until the result is taken; a
//   transaction that meets a free result register is taken in the same cycle
//   the old one leaves. Reset clears both positions, the full flag, the
//   overwrite bit and the result valid. Storage contents are undefined until
//   written; no byte is ever returned from a cell that was not written.
// ----------------------------------------------------------------------------
module byte_ring_fifo_overwrite #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_en,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  brfo_pkg::brfo_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output brfo_pkg::brfo_out_t out_data
);
    import brfo_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          accept;
    logic          out_taken;
    logic          we, re;
    logic [AW-1:0] addr;
    logic [7:0]    mem_q;
    brfo_meta_t    meta;

    assign out_taken = out_valid && !out_stall;
    assign in_stall  = out_valid && out_stall;
    assign accept    = in_valid && !in_stall;

    brfo_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (in_data),
        .out_taken (out_taken),
        .we        (we),
        .re        (re),
        .addr      (addr),
        .out_valid (out_valid),
        .meta      (meta)
    );

    brfo_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (addr),
        .wdata (in_data.wdata),
        .re    (re),
        .raddr (addr),
        .rdata (mem_q)
    );

    // rdata is zero unless the operation actually read a byte
    always_comb
    begin
        out_data.rdata    = meta.rd_ok ? mem_q : 8'd0;
        out_data.status   = meta.status;
        out_data.is_full  = meta.is_full;
        out_data.is_empty = meta.is_empty;
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte ring FIFO with overwrite. A scoreboard
// tracks the ring contents, positions, full flag and overwrite bit and
// predicts each reply. Stimulus is a short directed sequence of edge cases
// followed by random phases of biased write/read/peek mixes. Each phase has
// its own overwrite setting. Random gaps and stalls are used on both sides.
// ----------------------------------------------------------------------------
module tb;
    import brfo_pkg::*;

    // mode code with no operation behind it
    localparam logic [1:0] MODE_SPARE = 2'd3;

    class ring_checker;
        logic [7:0] cells [DEPTH_DEF];
        int         wr_ptr;
        int         rd_ptr;
        bit         full;
        bit         overwrite;
        int         errors;
        brfo_out_t  pending_replies [$];

        function new();
            wr_ptr    = 0;
            rd_ptr    = 0;
            full      = 1'b0;
            overwrite = 1'b0;
            errors    = 0;
        endfunction

        function int step_ptr(int p);
            return (p == DEPTH_DEF - 1) ? 0 : p + 1;
        endfunction

        function bit ring_empty();
            return (wr_ptr == rd_ptr) && !full;
        endfunction

        // called for each accepted input transaction
        function void take_op(brfo_in_t op);
            brfo_out_t r;
            r        = '0;
            r.status = STATUS_OK;
            case (op.mode) inside
                MODE_WRITE:
                begin
                    if (full)
                    begin
                        r.status = STATUS_FULL;
                    end
                    else
                    begin
                        cells[wr_ptr] = op.wdata;
                        wr_ptr = step_ptr(wr_ptr);
                        if (wr_ptr == rd_ptr)
                        begin
                            if (overwrite)
                            begin
                                rd_ptr   = step_ptr(rd_ptr);
                                r.status = STATUS_DROPPED;
                            end
                            else
                            begin
                                full = 1'b1;
                            end
                        end
                    end
                end
                MODE_READ, MODE_PEEK:
                begin
                    if (ring_empty())
                    begin
                        r.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        r.rdata = cells[rd_ptr];
                        if (op.mode == MODE_READ)
                        begin
                            rd_ptr = step_ptr(rd_ptr);
                            full   = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // unused mode: no-op, flags still reported
                end
            endcase
            r.is_full  = full;
            r.is_empty = ring_empty();
            pending_replies.push_back(r);
        endfunction

        function void compare_field(string fname, int exp_v, int got_v);
            if (exp_v != got_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, fname, exp_v, got_v);
            end
        endfunction

        // called for each accepted result transaction
        function void check_reply(brfo_out_t got);
            brfo_out_t exp_r;
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual %0h", $time, got);
                return;
            end
            exp_r = pending_replies.pop_front();
            compare_field("rdata", int'(exp_r.rdata), int'(got.rdata));
            compare_field("status", int'(exp_r.status), int'(got.status));
            compare_field("is_full", int'(exp_r.is_full), int'(got.is_full));
            compare_field("is_empty", int'(exp_r.is_empty), int'(got.is_empty));
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cfg_en;
    logic      cfg_data;
    logic      in_valid;
    logic      in_stall;
    brfo_in_t  in_data;
    logic      out_valid;
    logic      out_stall;
    brfo_out_t out_data;

    ring_checker sb;
    bit          calm;
    bit          long_hold_req;

    byte_ring_fifo_overwrite DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // mostly zero, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    task automatic send_op(logic [1:0] m, logic [7:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_data.mode  <= m;
        in_data.wdata <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.take_op('{mode: m, wdata: d});
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_replies.size() != 0) @(posedge clk);
    endtask

    task automatic write_overwrite(bit v);
        drain();
        repeat (2) @(posedge clk);
        cfg_en   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_en   <= 1'b0;
        sb.overwrite = v;
    endtask

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin : receiver
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = 120;
            end
            else if (hold == 0)
            begin
                hold = pick_gap();
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : result_monitor
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_reply(out_data);
        end
    end

    initial
    begin : stimulus
        int         total;
        int         phase;
        int         plen;
        int         wr_pct;
        int         r;
        logic [1:0] m;
        int         mix [5];
        sb            = new();
        mix           = '{10, 30, 50, 70, 90};
        calm          = 1'b0;
        long_hold_req = 1'b0;
        rst_n         = 1'b0;
        cfg_en        = 1'b0;
        cfg_data      = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring, unused mode, byte extremes
        send_op(MODE_READ, 8'h5A);
        send_op(MODE_PEEK, 8'hA5);
        send_op(MODE_SPARE, 8'hFF);
        send_op(MODE_WRITE, 8'h00);
        send_op(MODE_WRITE, 8'hFF);
        send_op(MODE_PEEK, 8'h00);
        send_op(MODE_READ, 8'h00);
        // fill up to full, then one rejected write
        for (int i = 0; i < DEPTH_DEF - 1; i++)
            send_op(MODE_WRITE, 8'($urandom));
        send_op(MODE_WRITE, 8'h77);
        // full flag survives the switch to overwrite mode
        write_overwrite(1'b1);
        send_op(MODE_WRITE, 8'h11);
        send_op(MODE_READ, 8'h00);
        send_op(MODE_WRITE, 8'h22);

        total = 0;
        phase = 0;
        while (total < 1150)
        begin
            write_overwrite(phase < 2 ? phase[0] : 1'($urandom_range(1)));
            calm   = ($urandom_range(3) == 0);
            wr_pct = mix[$urandom_range(4)];
            plen   = $urandom_range(70, 30);
            if (phase % 6 == 1)
            begin
                // receiver holds off while the sender keeps pushing
                wr_pct = 85;
                long_hold_req = 1'b1;
            end
            for (int i = 0; i < plen; i++)
            begin
                r = $urandom_range(99);
                if (r < wr_pct)
                    m = MODE_WRITE;
                else if (r < wr_pct + (100 - wr_pct) * 6 / 10)
                    m = MODE_READ;
                else if ($urandom_range(9) != 0)
                    m = MODE_PEEK;
                else
                    m = MODE_SPARE;
                send_op(m, 8'($urandom));
            end
            total += plen;
            phase++;
        end

        drain();
        repeat (5) @(posedge clk);
        if (sb.errors == 0 && sb.pending_replies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
